### hdl/lpr_pkg.sv
// Shared types, constants and helpers for the longest-prefix route engine.
package lpr_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int PORT_COUNT  = 16;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int PORT_W  = 4;
    localparam int TTL_W   = 8;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    localparam int MAX_LEN = 32;

    // Request kinds.
    localparam logic REQ_ADD     = 1'b0;
    localparam logic REQ_FORWARD = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_ADDED       = 3'd0;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FORWARDED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_ROUTE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_TTL_EXPIRED = 3'd4;

    // One stored route.
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              direct;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } route_t;

    // Lookup item walking the cell chain, carrying the best match so far.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] dest;
        logic [TTL_W-1:0]  ttl;
        logic              found;
        logic [LEN_W-1:0]  best_len;
        logic              best_direct;
        logic [ADDR_W-1:0] best_hop;
        logic [PORT_W-1:0] best_port;
    } probe_t;

    // One result item.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] hop;
        logic [TTL_W-1:0]  ttl;
    } result_t;

    // Folds an output port number into the range of existing ports.
    function automatic logic [PORT_W-1:0] port_wrap(input logic [PORT_W-1:0] p);
        logic [PORT_W-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << PORT_W); i++)
        begin
            if (p == PORT_W'(i))
            begin
                r = PORT_W'(i % PORT_COUNT);
            end
        end
        return r;
    endfunction

endpackage

### hdl/lpr_req_if.sv
// Request channel: add-route and forward items with valid/ready handshake.
interface lpr_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [lpr_pkg::ADDR_W-1:0]      add_prefix;
    logic [lpr_pkg::LEN_W-1:0]       prefix_len;
    logic                            has_next_hop;
    logic [lpr_pkg::ADDR_W-1:0]      next_hop_addr;
    logic [lpr_pkg::PORT_W-1:0]      out_port;
    logic [lpr_pkg::ADDR_W-1:0]      dest_addr;
    logic [lpr_pkg::TTL_W-1:0]       ttl_in;

    modport source (
        output valid, req_type, add_prefix, prefix_len, has_next_hop,
               next_hop_addr, out_port, dest_addr, ttl_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, add_prefix, prefix_len, has_next_hop,
               next_hop_addr, out_port, dest_addr, ttl_in,
        output ready
    );
endinterface

### hdl/lpr_res_if.sv
// Result channel: status, port, hop address and TTL with valid/ready handshake.
interface lpr_res_if;
    logic                            valid;
    logic                            ready;
    logic [lpr_pkg::STAT_W-1:0]      status;
    logic [lpr_pkg::PORT_W-1:0]      port_out;
    logic [lpr_pkg::ADDR_W-1:0]      hop_addr;
    logic [lpr_pkg::TTL_W-1:0]       ttl_out;

    modport source (
        output valid, status, port_out, hop_addr, ttl_out,
        input  ready
    );
    modport sink (
        input  valid, status, port_out, hop_addr, ttl_out,
        output ready
    );
endinterface

### hdl/ipv4_longest_prefix_router.sv
// Forward lookup: the lookup walks the cell registers in order, one cell a cycle, then goes
// through the pending and output registers. Add route: the status goes through the pending and
// output registers; the route is written straight into its cell. One item is in work at a time;
// the next item is accepted once the result reaches the output register.
// A finished result may wait in the output register while the next item is being worked on.
// Reset (rst_n, asynchronous, active low) empties the table and clears all handshake state.
module ipv4_longest_prefix_router (
    input  logic        clk,
    input  logic        rst_n,
    lpr_req_if.sink     req,
    lpr_res_if.source   res
);

    localparam int DEPTH = lpr_pkg::TABLE_DEPTH;

    logic [lpr_pkg::CNT_W-1:0] entry_count_reg, entry_count_next;
    logic                      busy_reg, busy_next;
    logic                      pend_valid_reg, pend_valid_next;
    lpr_pkg::result_t          pend_res_reg, pend_res_next;
    logic                      out_valid_reg, out_valid_next;
    lpr_pkg::result_t          out_res_reg, out_res_next;

    logic            accept;
    logic            is_add;
    logic            full;
    logic            move;
    lpr_pkg::route_t wr_route;
    lpr_pkg::probe_t inject;
    lpr_pkg::probe_t probe [DEPTH];
    lpr_pkg::probe_t last;
    logic [DEPTH-1:0] wr_en;
    logic [DEPTH-1:0] occupied;
    logic [DEPTH-1:0] probe_valid;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && req.ready;
    assign is_add    = (req.req_type == lpr_pkg::REQ_ADD);
    assign full      = (entry_count_reg == lpr_pkg::CNT_W'(DEPTH));

    always_comb
    begin
        wr_route.prefix = req.add_prefix;
        wr_route.len    = req.prefix_len;
        wr_route.direct = !req.has_next_hop;
        wr_route.hop    = req.next_hop_addr;
        wr_route.port   = lpr_pkg::port_wrap(req.out_port);

        inject             = '0;
        inject.valid       = accept && (req.req_type == lpr_pkg::REQ_FORWARD);
        inject.dest        = req.dest_addr;
        inject.ttl         = req.ttl_in;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign wr_en[i]       = accept && is_add && !full &&
                                (entry_count_reg == lpr_pkg::CNT_W'(i));
        assign occupied[i]    = (lpr_pkg::CNT_W'(i) < entry_count_reg);
        assign probe_valid[i] = probe[i].valid;

        if (i == 0)
        begin : g_head
            lpr_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (wr_en[i]),
                .wr_route  (wr_route),
                .occupied  (occupied[i]),
                .probe_in  (inject),
                .probe_out (probe[i])
            );
        end
        else
        begin : g_body
            lpr_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (wr_en[i]),
                .wr_route  (wr_route),
                .occupied  (occupied[i]),
                .probe_in  (probe[i-1]),
                .probe_out (probe[i])
            );
        end
    end

    assign last = probe[DEPTH-1];
    assign move = pend_valid_reg && (!out_valid_reg || res.ready);

    always_comb
    begin
        entry_count_next = entry_count_reg;
        busy_next        = busy_reg;
        pend_valid_next  = pend_valid_reg;
        pend_res_next    = pend_res_reg;
        out_valid_next   = out_valid_reg;
        out_res_next     = out_res_reg;

        if (accept && is_add && !full)
        begin
            entry_count_next = entry_count_reg + lpr_pkg::CNT_W'(1);
        end

        if (move)
        begin
            pend_valid_next = 1'b0;
        end

        if (accept && is_add)
        begin
            pend_valid_next      = 1'b1;
            pend_res_next        = '0;
            pend_res_next.status = full ? lpr_pkg::ST_TABLE_FULL : lpr_pkg::ST_ADDED;
        end
        else if (last.valid)
        begin
            pend_valid_next = 1'b1;
            pend_res_next   = '0;
            // A missing route outranks an expired TTL.
            priority if (!last.found)
            begin
                pend_res_next.status = lpr_pkg::ST_NO_ROUTE;
            end
            else if (last.ttl[lpr_pkg::TTL_W-1:1] == '0)
            begin
                pend_res_next.status = lpr_pkg::ST_TTL_EXPIRED;
            end
            else
            begin
                pend_res_next.status = lpr_pkg::ST_FORWARDED;
                pend_res_next.port   = last.best_port;
                pend_res_next.hop    = last.best_direct ? last.dest : last.best_hop;
                pend_res_next.ttl    = last.ttl - lpr_pkg::TTL_W'(1);
            end
        end

        if (move)
        begin
            out_valid_next = 1'b1;
            out_res_next   = pend_res_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (move)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            busy_reg        <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_res_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_res_reg     <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            busy_reg        <= busy_next;
            pend_valid_reg  <= pend_valid_next;
            pend_res_reg    <= pend_res_next;
            out_valid_reg   <= out_valid_next;
            out_res_reg     <= out_res_next;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.status   = out_res_reg.status;
    assign res.port_out = out_res_reg.port;
    assign res.hop_addr = out_res_reg.hop;
    assign res.ttl_out  = out_res_reg.ttl;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= lpr_pkg::CNT_W'(DEPTH))
        else $error("route count beyond table depth");

    a_single_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(probe_valid))
        else $error("more than one lookup in the cell chain");

    a_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (probe_valid == '0) && !pend_valid_reg)
        else $error("ready raised while an item is still in work");

    a_probe_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == lpr_pkg::REQ_FORWARD)) |=> probe_valid[0])
        else $error("accepted lookup did not enter the first cell");

    a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_add && full) |=> $stable(entry_count_reg))
        else $error("add into a full table changed the route count");

endmodule

### hdl/lpr_cell.sv
// One route cell: holds a route and updates the passing lookup's best match.
module lpr_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  lpr_pkg::route_t wr_route,
    input  logic            occupied,
    input  lpr_pkg::probe_t probe_in,
    output lpr_pkg::probe_t probe_out
);

    lpr_pkg::route_t route_reg;
    lpr_pkg::probe_t probe_reg;
    lpr_pkg::probe_t probe_next;

    logic [lpr_pkg::ADDR_W-1:0] mask;
    logic                       hit;
    logic                       take;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            route_reg <= wr_route;
        end
    end

    // The mask keeps the top len bits; a length above 32 never matches.
    always_comb
    begin
        mask = ~({lpr_pkg::ADDR_W{1'b1}} >> route_reg.len);
        hit  = occupied && (route_reg.len <= lpr_pkg::LEN_W'(lpr_pkg::MAX_LEN)) &&
               (((route_reg.prefix ^ probe_in.dest) & mask) == '0);
        // Later cells hold later routes, so an equal length replaces the best.
        take = hit && (!probe_in.found || (route_reg.len >= probe_in.best_len));

        probe_next = probe_in;
        if (take)
        begin
            probe_next.found       = 1'b1;
            probe_next.best_len    = route_reg.len;
            probe_next.best_direct = route_reg.direct;
            probe_next.best_hop    = route_reg.hop;
            probe_next.best_port   = route_reg.port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

### tb/sv/route_lookup_checker.sv
// Watches both channels, predicts each route-engine reply and compares it field by field.
`timescale 1ns / 1ps

module route_lookup_checker
    import lpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lpr_req_if   req,
    lpr_res_if   res,
    output int   mismatches,
    output int   outstanding,
    output int   compared
);

    // Private copy of the route table, filled in add order.
    logic [ADDR_W-1:0] tbl_prefix [TABLE_DEPTH];
    logic [LEN_W-1:0]  tbl_len    [TABLE_DEPTH];
    logic              tbl_direct [TABLE_DEPTH];
    logic [ADDR_W-1:0] tbl_hop    [TABLE_DEPTH];
    logic [PORT_W-1:0] tbl_port   [TABLE_DEPTH];
    int                tbl_count = 0;

    result_t           awaited_replies [$];
    result_t           oldest;
    int                errors_seen = 0;
    int                replies_seen = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR: %s", $time, what);
        errors_seen++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %h, wanted %h", name, got, want));
        end
    endtask

    // Applies one request to the private table and returns the reply it should cause.
    function automatic result_t predict_reply(
        input logic              kind,
        input logic [ADDR_W-1:0] prefix,
        input logic [LEN_W-1:0]  len,
        input logic              has_hop,
        input logic [ADDR_W-1:0] hop,
        input logic [PORT_W-1:0] port,
        input logic [ADDR_W-1:0] dest,
        input logic [TTL_W-1:0]  ttl
    );
        result_t           r;
        int                best;
        int                i;
        logic [LEN_W-1:0]  best_len;
        logic [63:0]       wide_mask;
        logic [ADDR_W-1:0] mask;
        r = '0;
        best = -1;
        best_len = '0;
        if (kind == REQ_ADD)
        begin
            if (tbl_count >= TABLE_DEPTH)
            begin
                r.status = ST_TABLE_FULL;
            end
            else
            begin
                tbl_prefix[tbl_count] = prefix;
                tbl_len[tbl_count]    = len;
                tbl_direct[tbl_count] = !has_hop;
                tbl_hop[tbl_count]    = hop;
                tbl_port[tbl_count]   = PORT_W'(port % PORT_COUNT);
                tbl_count++;
                r.status = ST_ADDED;
            end
        end
        else
        begin
            for (i = 0; i < tbl_count; i++)
            begin
                // A length above 32 bits can never match.
                if (tbl_len[i] <= MAX_LEN)
                begin
                    wide_mask = 64'hFFFF_FFFF_0000_0000 >> tbl_len[i];
                    mask = wide_mask[31:0];
                    // Ties on length go to the later entry, hence the >=.
                    if (((tbl_prefix[i] ^ dest) & mask) == '0 &&
                        (best < 0 || tbl_len[i] >= best_len))
                    begin
                        best = i;
                        best_len = tbl_len[i];
                    end
                end
            end
            if (best < 0)
            begin
                r.status = ST_NO_ROUTE;
            end
            else if (ttl <= 1)
            begin
                r.status = ST_TTL_EXPIRED;
            end
            else
            begin
                r.status = ST_FORWARDED;
                r.port   = tbl_port[best];
                r.hop    = tbl_direct[best] ? dest : tbl_hop[best];
                r.ttl    = ttl - 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_count = 0;
            awaited_replies.delete();
            errors_seen = 0;
            replies_seen = 0;
            mismatches <= 0;
            outstanding <= 0;
            compared <= 0;
        end
        else
        begin
            // A reply leaving now always belongs to an earlier request.
            if (res.valid && res.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    report_mismatch("reply arrived with no request outstanding");
                end
                else
                begin
                    oldest = awaited_replies.pop_front();
                    replies_seen++;
                    check_field("status", 32'(res.status), 32'(oldest.status));
                    check_field("port_out", 32'(res.port_out), 32'(oldest.port));
                    check_field("hop_addr", res.hop_addr, oldest.hop);
                    check_field("ttl_out", 32'(res.ttl_out), 32'(oldest.ttl));
                end
            end
            if (req.valid && req.ready)
            begin
                awaited_replies.push_back(predict_reply(req.req_type, req.add_prefix,
                    req.prefix_len, req.has_next_hop, req.next_hop_addr, req.out_port,
                    req.dest_addr, req.ttl_in));
            end
            mismatches <= errors_seen;
            outstanding <= awaited_replies.size();
            compared <= replies_seen;
        end
    end

endmodule

### tb/sv/testbench.sv
// Top of the route-engine regression: clock, reset, request stimulus, reply stalls, verdict.
`timescale 1ns / 1ps

module testbench;
    import lpr_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct {
        logic              kind;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              has_hop;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] dest;
        logic [TTL_W-1:0]  ttl;
    } route_request_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_BURSTY,
        READY_COIN
    } stall_mode_t;

    logic clk;
    logic rst_n;
    logic sink_ready = 1'b0;

    int mismatch_total;
    int awaited;
    int compared;

    int cycle_count = 0;
    int sent_count = 0;
    int add_count = 0;
    int burst_left = 1;

    // Prefixes and lengths of the first TABLE_DEPTH adds sent, used to aim destinations at routes.
    logic [ADDR_W-1:0] aimed_prefix [$];
    int unsigned       aimed_len [$];

    stall_mode_t stall_mode = READY_ALWAYS;
    int          mode_left = 0;
    int          stall_left = 0;

    lpr_req_if req ();
    lpr_res_if res ();

    assign res.ready = sink_ready;

    ipv4_longest_prefix_router dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    route_lookup_checker lookup_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res         (res),
        .mismatches  (mismatch_total),
        .outstanding (awaited),
        .compared    (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d replies outstanding",
                     CYCLE_LIMIT, awaited);
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver switches at random between stall styles, holding each for a random spell.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (stall_mode)
                READY_ALWAYS: sink_ready <= 1'b1;
                READY_MOSTLY: sink_ready <= ($urandom_range(0, 3) != 0);
                READY_BURSTY:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        sink_ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        stall_left = $urandom_range(1, 30);
                        sink_ready <= 1'b0;
                    end
                    else
                    begin
                        sink_ready <= 1'b1;
                    end
                end
                default: sink_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    function automatic logic [ADDR_W-1:0] prefix_mask(input int unsigned len);
        logic [63:0] wide;
        wide = 64'hFFFF_FFFF_0000_0000 >> len;
        return wide[31:0];
    endfunction

    // Fields that an add does not use still get random values.
    function automatic route_request_t make_add(
        input logic [ADDR_W-1:0] prefix,
        input logic [LEN_W-1:0]  len,
        input logic              has_hop,
        input logic [ADDR_W-1:0] hop,
        input logic [PORT_W-1:0] port
    );
        route_request_t r;
        r.kind    = REQ_ADD;
        r.prefix  = prefix;
        r.len     = len;
        r.has_hop = has_hop;
        r.hop     = hop;
        r.port    = port;
        r.dest    = $urandom;
        r.ttl     = TTL_W'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic route_request_t make_forward(
        input logic [ADDR_W-1:0] dest,
        input logic [TTL_W-1:0]  ttl
    );
        route_request_t r;
        r.kind    = REQ_FORWARD;
        r.prefix  = $urandom;
        r.len     = LEN_W'($urandom_range(0, 63));
        r.has_hop = 1'($urandom_range(0, 1));
        r.hop     = $urandom;
        r.port    = PORT_W'($urandom_range(0, 15));
        r.dest    = dest;
        r.ttl     = ttl;
        return r;
    endfunction

    // Builds a route that nests under, ties with, or stands apart from those already sent.
    // The last free slot always gets the default route.
    function automatic route_request_t next_route();
        int                pick;
        int                stored;
        int                base;
        int unsigned       len;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        stored = aimed_prefix.size();
        pick = $urandom_range(0, 9);
        prefix = $urandom;
        len = $urandom_range(1, MAX_LEN);
        base = (stored == 0) ? 0 : $urandom_range(0, stored - 1);
        if (stored == TABLE_DEPTH - 1)
        begin
            len = 0;
        end
        else if (stored >= TABLE_DEPTH)
        begin
            len = $urandom_range(0, 63);
        end
        else if (pick >= 4 && pick <= 7 && stored > 0 && aimed_len[base] <= MAX_LEN)
        begin
            len = (pick <= 5) ? $urandom_range(aimed_len[base], MAX_LEN) : aimed_len[base];
            mask = prefix_mask(aimed_len[base]);
            prefix = (aimed_prefix[base] & mask) | (prefix & ~mask);
        end
        else if (pick == 8)
        begin
            len = $urandom_range(MAX_LEN + 1, 63);
        end
        else if (pick == 9)
        begin
            len = MAX_LEN;
        end
        return make_add(prefix, LEN_W'(len), 1'($urandom_range(0, 1)), $urandom,
                        PORT_W'($urandom_range(0, 15)));
    endfunction

    // Most destinations land inside a route already sent; the rest are arbitrary.
    function automatic route_request_t next_datagram();
        int                pick;
        int                tpick;
        int                stored;
        int                base;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [TTL_W-1:0]  ttl;
        stored = aimed_prefix.size();
        pick = $urandom_range(0, 9);
        dest = $urandom;
        if (stored > 0 && pick < 8)
        begin
            base = $urandom_range(0, stored - 1);
            if (pick == 7)
            begin
                dest = aimed_prefix[base];
            end
            else if (aimed_len[base] <= MAX_LEN)
            begin
                mask = prefix_mask(aimed_len[base]);
                dest = (aimed_prefix[base] & mask) | (dest & ~mask);
            end
        end
        tpick = $urandom_range(0, 9);
        if (tpick == 0)
        begin
            ttl = TTL_W'($urandom_range(0, 2));
        end
        else if (tpick == 1)
        begin
            ttl = '1;
        end
        else
        begin
            ttl = TTL_W'($urandom_range(0, 255));
        end
        return make_forward(dest, ttl);
    endfunction

    // Holds one item on the channel until it is taken, then maybe pauses between bursts.
    task automatic send_request(input route_request_t r);
        int gap;
        req.valid         <= 1'b1;
        req.req_type      <= r.kind;
        req.add_prefix    <= r.prefix;
        req.prefix_len    <= r.len;
        req.has_next_hop  <= r.has_hop;
        req.next_hop_addr <= r.hop;
        req.out_port      <= r.port;
        req.dest_addr     <= r.dest;
        req.ttl_in        <= r.ttl;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
        if (r.kind == REQ_ADD)
        begin
            add_count++;
            if (aimed_prefix.size() < TABLE_DEPTH)
            begin
                aimed_prefix.push_back(r.prefix);
                aimed_len.push_back(32'(r.len));
            end
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = REQ_ADD;
        req.add_prefix = '0;
        req.prefix_len = '0;
        req.has_next_hop = 1'b0;
        req.next_hop_addr = '0;
        req.out_port = '0;
        req.dest_addr = '0;
        req.ttl_in = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: no route wins even over an expired TTL.
        send_request(make_forward(32'h0000_0000, 8'hFF));
        send_request(make_forward(32'hFFFF_FFFF, 8'h00));
        send_request(make_add(32'hC0A8_0000, 6'd16, 1'b0, 32'h1234_5678, 4'd3));
        send_request(make_add(32'hC0A8_0100, 6'd24, 1'b1, 32'h0A0A_0A01, 4'd0));
        send_request(make_add(32'hC0A8_01FF, 6'd24, 1'b1, 32'hFFFF_FFFF, 4'd9));
        send_request(make_add(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0000_0000, 4'd15));
        send_request(make_add(32'h0000_0000, 6'd63, 1'b1, 32'h5555_5555, 4'd12));
        send_request(make_add(32'h0000_0000, 6'd32, 1'b1, 32'hAAAA_AAAA, 4'd5));
        send_request(make_forward(32'hC0A8_0105, 8'hFF));
        send_request(make_forward(32'hC0A8_FF01, 8'd64));
        send_request(make_forward(32'hFFFF_FFFF, 8'hFF));
        send_request(make_forward(32'hFFFF_FFFF, 8'd1));
        send_request(make_forward(32'hC0A8_0001, 8'd0));
        send_request(make_forward(32'hC0A8_0001, 8'd2));
        send_request(make_forward(32'h0000_0000, 8'd2));
        send_request(make_forward(32'h0000_0001, 8'd200));
        send_request(make_forward(32'hFFFF_FFFE, 8'd77));

        // Fill the table while forwarding, then keep probing it and pushing past full.
        while (sent_count < ITEM_TARGET)
        begin
            if (aimed_prefix.size() < TABLE_DEPTH ? ($urandom_range(0, 7) == 0)
                                                  : ($urandom_range(0, 19) == 0))
            begin
                send_request(next_route());
            end
            else
            begin
                send_request(next_datagram());
            end
        end

        req.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
        begin
            @(posedge clk);
        end
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("Sent %0d requests: %0d route adds and %0d forward lookups.",
                 sent_count, add_count, sent_count - add_count);
        $display("Compared %0d replies, %0d field mismatches.", compared, mismatch_total);
        if (mismatch_total == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
